// ===== design/segment_tree_range_max_defines.svh =====
// assertion macros for the segment tree range max block
// used by the top level only; clock and reset names are fixed by the house style
`ifndef SEGMENT_TREE_RANGE_MAX_DEFINES_SVH
`define SEGMENT_TREE_RANGE_MAX_DEFINES_SVH

// concurrent check on clk_i, off while rst_ni is low
`define STRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define STRM_ASSERT_IMP(lbl, ante, cons, msg) \
  `STRM_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== design/strm_pkg.sv =====
// shared types, constants and helpers for the segment tree range max block
// no dependencies
package strm_pkg;

  localparam int LEAVES_DEF = 1024;
  localparam int DATA_W     = 32;
  localparam int ROW_W      = 2 * DATA_W;
  localparam int IDX_W      = 10;
  localparam int OUT_W      = 31;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef enum logic [5:0] {
    ST_CLR    = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_UPD_RD = 6'b000100,
    ST_UPD_WR = 6'b001000,
    ST_QRY    = 6'b010000,
    ST_QDRN   = 6'b100000
  } state_e;

  // control from the sequencer to the query accumulator
  typedef struct packed {
    logic clr;
    logic issue;
    logic take_a;
    logic take_b;
  } acc_ctrl_t;

  function automatic logic signed [DATA_W-1:0] smax(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    smax = (a > b) ? a : b;
  endfunction

endpackage

// ===== design/strm_mem.sv =====
// node store: one row per sibling pair, one write port and two registered read ports
// depends on strm_pkg
module strm_mem #(
  parameter int AW = 9
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [strm_pkg::ROW_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_a_i,
  input  logic [AW-1:0]              raddr_b_i,
  output logic [strm_pkg::ROW_W-1:0] rdata_a_o,
  output logic [strm_pkg::ROW_W-1:0] rdata_b_o
);

  logic [strm_pkg::ROW_W-1:0] mem_q [2**AW];
  logic [strm_pkg::ROW_W-1:0] rdata_a_q;
  logic [strm_pkg::ROW_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/strm_accum.sv =====
// query accumulator: pairs the two node reads of a level, then folds into the running max
// depends on strm_pkg
module strm_accum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  strm_pkg::acc_ctrl_t               ctrl_i,
  input  logic [strm_pkg::ROW_W-1:0]        rdata_a_i,
  input  logic [strm_pkg::ROW_W-1:0]        rdata_b_i,
  output logic signed [strm_pkg::DATA_W-1:0] acc_o,
  output logic                              busy_o
);

  localparam int DW = strm_pkg::DATA_W;

  logic                 s1_v_q, ta_q, tb_q;
  logic                 s2_v_q;
  logic signed [DW-1:0] pm_q, pm_d;
  logic signed [DW-1:0] acc_q, acc_d;
  logic signed [DW-1:0] node_a, node_b;

  // left cursor is taken only when it is an odd node (upper half), right cursor only when even (lower half)
  always_comb begin
    node_a = ta_q ? rdata_a_i[2*DW-1:DW] : '0;
    node_b = tb_q ? rdata_b_i[DW-1:0] : '0;
    pm_d   = strm_pkg::smax(node_a, node_b);
    acc_d  = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (s2_v_q) begin
      acc_d = strm_pkg::smax(acc_q, pm_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      ta_q   <= 1'b0;
      tb_q   <= 1'b0;
      s2_v_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      s1_v_q <= ctrl_i.issue;
      ta_q   <= ctrl_i.take_a;
      tb_q   <= ctrl_i.take_b;
      s2_v_q <= s1_v_q;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pm_q <= pm_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = s1_v_q | s2_v_q;

endmodule

// ===== design/segment_tree_range_max.sv =====
// segment tree range max, point update; one item in flight at a time.
// update: one row read, then one read-modify-write per level through the single write port.
// query: two reads per level and two fold stages.
// reset: a clearing pass writes zero over all rows of the store, ready held low.
module segment_tree_range_max #(
  parameter int LEAVES = strm_pkg::LEAVES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic [strm_pkg::IDX_W-1:0]         first_index_i,
  input  logic [strm_pkg::IDX_W-1:0]         last_index_i,
  input  logic signed [strm_pkg::DATA_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [strm_pkg::OUT_W-1:0]         max_value_o
);

  `include "segment_tree_range_max_defines.svh"

  localparam int LW = $clog2(LEAVES);
  localparam int NW = LW + 1;
  localparam int CW = (NW > strm_pkg::IDX_W) ? NW : strm_pkg::IDX_W;
  localparam int DW = strm_pkg::DATA_W;
  localparam int RW = strm_pkg::ROW_W;

  strm_pkg::state_e state_q, state_d;

  logic [LW-1:0]        clr_q, clr_d;
  logic [NW-1:0]        node_q, node_d;
  logic signed [DW-1:0] val_q, val_d;
  logic [NW:0]          lo_q, lo_d, hi_q, hi_d;
  logic                 out_valid_q, out_valid_d;
  logic [strm_pkg::OUT_W-1:0] max_value_q, max_value_d;

  logic                 mem_we;
  logic [LW-1:0]        mem_waddr, raddr_a, raddr_b;
  logic [RW-1:0]        mem_wdata, rdata_a, rdata_b;

  strm_pkg::acc_ctrl_t  acc_ctrl;
  logic signed [DW-1:0] acc;
  logic                 acc_busy;

  logic [CW-1:0]        first_ext, last_ext;
  logic [LW-1:0]        last_sat;
  logic                 first_ok, q_empty;
  logic signed [DW-1:0] sibling;
  logic [RW-1:0]        row_new;

  logic                 in_query, in_drain, in_clear;

  always_comb begin
    first_ext = CW'(first_index_i);
    last_ext  = CW'(last_index_i);
    first_ok  = first_ext < CW'(LEAVES);
    last_sat  = (last_ext >= CW'(LEAVES)) ? LW'(LEAVES - 1) : last_ext[LW-1:0];
    q_empty   = !first_ok || (first_ext > CW'(last_sat));

    // sibling of the node just rewritten, and the row with the new value merged in
    if (node_q[0]) begin
      sibling = rdata_a[DW-1:0];
      row_new = {val_q, rdata_a[DW-1:0]};
    end else begin
      sibling = rdata_a[RW-1:DW];
      row_new = {rdata_a[RW-1:DW], val_q};
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_d      = node_q;
    val_d       = val_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q && !out_ready_i;
    max_value_d = max_value_q;
    mem_we      = 1'b0;
    mem_waddr   = LW'(node_q >> 1);
    mem_wdata   = row_new;
    raddr_a     = LW'(lo_q >> 1);
    raddr_b     = LW'(hi_q >> 1);
    acc_ctrl    = '0;

    unique case (state_q)
      strm_pkg::ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + LW'(1);
        if (clr_q == {LW{1'b1}}) begin
          state_d = strm_pkg::ST_IDLE;
        end
      end
      strm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == strm_pkg::ACT_QUERY) begin
            acc_ctrl.clr = 1'b1;
            if (q_empty) begin
              lo_d = (NW+1)'(1);
              hi_d = '0;
            end else begin
              lo_d = (NW+1)'(LEAVES) + (NW+1)'(first_ext[LW-1:0]);
              hi_d = (NW+1)'(LEAVES) + (NW+1)'(last_sat);
            end
            state_d = strm_pkg::ST_QRY;
          end else if (first_ok) begin
            node_d  = NW'(LEAVES) + NW'(first_ext[LW-1:0]);
            val_d   = value_i;
            state_d = strm_pkg::ST_UPD_RD;
          end
        end
      end
      strm_pkg::ST_UPD_RD: begin
        raddr_a = LW'(node_q >> 1);
        state_d = strm_pkg::ST_UPD_WR;
      end
      strm_pkg::ST_UPD_WR: begin
        mem_we  = 1'b1;
        // next row read overlaps this write; it is the parent row, but at the root row it is this one
        raddr_a = LW'(node_q >> 2);
        if (LW'(node_q >> 1) == '0) begin
          state_d = strm_pkg::ST_IDLE;
        end else begin
          node_d = node_q >> 1;
          val_d  = strm_pkg::smax(val_q, sibling);
        end
      end
      strm_pkg::ST_QRY: begin
        if (lo_q <= hi_q) begin
          acc_ctrl.issue  = 1'b1;
          acc_ctrl.take_a = lo_q[0];
          acc_ctrl.take_b = !hi_q[0];
          lo_d = (lo_q + (NW+1)'(lo_q[0])) >> 1;
          hi_d = (hi_q - (NW+1)'(!hi_q[0])) >> 1;
        end else begin
          state_d = strm_pkg::ST_QDRN;
        end
      end
      strm_pkg::ST_QDRN: begin
        if (!acc_busy && (!out_valid_q || out_ready_i)) begin
          out_valid_d = 1'b1;
          max_value_d = acc[strm_pkg::OUT_W-1:0];
          state_d     = strm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = strm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= strm_pkg::ST_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q      <= node_d;
    val_q       <= val_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    max_value_q <= max_value_d;
  end

  strm_mem #(
    .AW(LW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  strm_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (acc_ctrl),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .acc_o     (acc),
    .busy_o    (acc_busy)
  );

  assign in_ready_o  = (state_q == strm_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign max_value_o = max_value_q;

  assign in_query = (state_q == strm_pkg::ST_QRY) || (state_q == strm_pkg::ST_QDRN);
  assign in_drain = (state_q == strm_pkg::ST_QDRN);
  assign in_clear = (state_q == strm_pkg::ST_CLR);

  `STRM_ASSERT_IMP(a_no_write_in_query, in_query, !mem_we, "store written during a query")
  `STRM_ASSERT_IMP(a_result_from_drain, $rose(out_valid_o), $past(in_drain), "stray result")
  `STRM_ASSERT_IMP(a_no_accept_in_clear, in_clear, !in_ready_o, "ready during clearing pass")
  `STRM_ASSERT(a_acc_nonneg, !acc[DW-1], "running max went negative")

endmodule
